// ----- design/rapwm_pkg.sv -----
// ----------------------------------------------------------------------------
// rapwm_pkg
// shared types, codes and sizes of the access point whitelist matcher
// ----------------------------------------------------------------------------
package rapwm_pkg;

    // table geometry
    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // field widths
    localparam int OP_W   = 3;
    localparam int LEN_W  = 6;
    localparam int ADDR_W = 48;
    localparam int CH_W   = 8;
    localparam int ST_W   = 3;
    localparam int EV_W   = 2;
    localparam int OUT_IDX_W = 4;
    localparam int TOT_W  = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEN   = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_CH    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_ROGUE    = 2'd1;
    localparam logic [EV_W-1:0] EV_MISMATCH = 2'd2;

    // name sanitizing and channel range
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_COMMA      = 8'h2c;
    localparam logic [7:0] CHAR_BAR        = 8'h7c;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [CH_W-1:0] CH_MAX     = 8'd14;

    // one whitelist entry as held in the table memory
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [CH_W-1:0]   ch;
    } entry_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             finish;
    } cmd_t;

endpackage

// ----- design/rapwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rapwm_ctrl
// sequencer: takes a beat, scans the table once, commits and posts the result
// ----------------------------------------------------------------------------
module rapwm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output rapwm_pkg::cmd_t  cmd
);

    rapwm_pkg::state_t             state_reg, state_next;
    logic [rapwm_pkg::IDX_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          slot_free;
    logic                          scan_last;

    assign slot_free = !out_valid_reg || !out_stall;
    assign scan_last = (scan_cnt_reg == rapwm_pkg::IDX_W'(rapwm_pkg::ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rapwm_pkg::S_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            rapwm_pkg::S_IDLE:
            begin
                scan_cnt_next = '0;
                if (in_valid)
                    state_next = rapwm_pkg::S_SCAN;
            end
            rapwm_pkg::S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_last)
                    state_next = rapwm_pkg::S_DRAIN;
            end
            rapwm_pkg::S_DRAIN:
            begin
                state_next = rapwm_pkg::S_FINISH;
            end
            rapwm_pkg::S_FINISH:
            begin
                if (slot_free)
                    state_next = rapwm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rapwm_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            rapwm_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            rapwm_pkg::S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = scan_cnt_reg;
            end
            rapwm_pkg::S_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            rapwm_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/rapwm_dp.sv -----
// ----------------------------------------------------------------------------
// rapwm_dp
// datapath: item registers, table memory, match compare, counters, result
// ----------------------------------------------------------------------------
module rapwm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rapwm_pkg::cmd_t                   cmd,
    input  logic [rapwm_pkg::OP_W-1:0]        opcode,
    input  logic [rapwm_pkg::LEN_W-1:0]       name_length,
    input  logic [63:0]                       name_bytes_0_7,
    input  logic [63:0]                       name_bytes_8_15,
    input  logic [63:0]                       name_bytes_16_23,
    input  logic [63:0]                       name_bytes_24_31,
    input  logic [rapwm_pkg::ADDR_W-1:0]      station_address,
    input  logic [rapwm_pkg::CH_W-1:0]        radio_channel,
    output logic [rapwm_pkg::ST_W-1:0]        status,
    output logic [rapwm_pkg::EV_W-1:0]        event_kind,
    output logic [rapwm_pkg::OUT_IDX_W-1:0]   entry_index,
    output logic [rapwm_pkg::ADDR_W-1:0]      expected_address,
    output logic [rapwm_pkg::CH_W-1:0]        expected_channel,
    output logic [rapwm_pkg::TOT_W-1:0]       alert_total,
    output logic [rapwm_pkg::TOT_W-1:0]       sweep_total,
    output logic [rapwm_pkg::CNT_W-1:0]       entries_in_use
);

    localparam int NB = rapwm_pkg::NAME_BYTES;

    // table memory
    rapwm_pkg::entry_t mem [rapwm_pkg::ENTRIES];
    rapwm_pkg::entry_t rd_data_reg;
    logic              rd_valid_reg;
    logic [rapwm_pkg::IDX_W-1:0] rd_idx_reg;

    // item registers
    logic [rapwm_pkg::OP_W-1:0]   op_reg;
    logic [rapwm_pkg::LEN_W-1:0]  len_reg;
    logic [rapwm_pkg::NAME_W-1:0] key_reg;
    logic [rapwm_pkg::ADDR_W-1:0] addr_reg;
    logic [rapwm_pkg::CH_W-1:0]   ch_reg;

    // scan results
    logic                         found_reg, free_found_reg;
    logic [rapwm_pkg::IDX_W-1:0]  match_idx_reg, free_idx_reg;
    logic [rapwm_pkg::ADDR_W-1:0] match_addr_reg;
    logic [rapwm_pkg::CH_W-1:0]   match_ch_reg;

    // table state and counters
    logic [rapwm_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [rapwm_pkg::CNT_W-1:0]   used_reg, used_next;
    logic [rapwm_pkg::TOT_W-1:0]   alert_reg, alert_next;
    logic [rapwm_pkg::TOT_W-1:0]   sweep_reg, sweep_next;

    // result register
    logic [rapwm_pkg::ST_W-1:0]      status_reg, status_next;
    logic [rapwm_pkg::EV_W-1:0]      ev_reg, ev_next;
    logic [rapwm_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [rapwm_pkg::ADDR_W-1:0]    eaddr_reg, eaddr_next;
    logic [rapwm_pkg::CH_W-1:0]      ech_reg, ech_next;

    logic [255:0]                 name_in;
    logic [rapwm_pkg::NAME_W-1:0] key_next;
    logic                         hit;
    logic                         wr_en;
    logic [rapwm_pkg::IDX_W-1:0]  wr_idx;
    rapwm_pkg::entry_t            wr_data;

    assign name_in = {name_bytes_24_31, name_bytes_16_23, name_bytes_8_15, name_bytes_0_7};

    // name key: bytes past the length zeroed, add also sanitizes
    always_comb
    begin
        logic [7:0] b;
        logic       keep;
        key_next = '0;
        for (int i = 0; i < NB; i++)
        begin
            b    = name_in[8*i +: 8];
            keep = (rapwm_pkg::LEN_W'(i) < name_length);
            if (!keep)
                key_next[8*i +: 8] = 8'h00;
            else if ((opcode == rapwm_pkg::OP_ADD) &&
                     (b == rapwm_pkg::CHAR_COMMA || b == rapwm_pkg::CHAR_BAR ||
                      b < rapwm_pkg::CHAR_SPACE))
                key_next[8*i +: 8] = rapwm_pkg::CHAR_UNDERSCORE;
            else
                key_next[8*i +: 8] = b;
        end
    end

    assign hit = rd_valid_reg && valid_reg[rd_idx_reg] &&
                 (rd_data_reg.len == len_reg) && (rd_data_reg.name == key_reg);

    // commit decision
    always_comb
    begin
        status_next = rapwm_pkg::ST_OK;
        ev_next     = rapwm_pkg::EV_NONE;
        idx_next    = '0;
        eaddr_next  = '0;
        ech_next    = '0;
        wr_en       = 1'b0;
        wr_idx      = match_idx_reg;
        valid_next  = valid_reg;
        used_next   = used_reg;
        alert_next  = alert_reg;
        sweep_next  = sweep_reg;
        case (op_reg)
            rapwm_pkg::OP_CHECK:
            begin
                if (found_reg)
                begin
                    idx_next   = match_idx_reg;
                    eaddr_next = match_addr_reg;
                    ech_next   = match_ch_reg;
                    if (match_addr_reg != addr_reg)
                        ev_next = rapwm_pkg::EV_ROGUE;
                    else if (match_ch_reg != '0 && match_ch_reg != ch_reg)
                        ev_next = rapwm_pkg::EV_MISMATCH;
                    if (ev_next != rapwm_pkg::EV_NONE)
                        alert_next = alert_reg + 1'b1;
                end
            end
            rapwm_pkg::OP_ADD:
            begin
                if (len_reg == '0 || len_reg > rapwm_pkg::LEN_W'(NB))
                    status_next = rapwm_pkg::ST_BAD_LEN;
                else if (ch_reg > rapwm_pkg::CH_MAX)
                    status_next = rapwm_pkg::ST_BAD_CH;
                else if (found_reg)
                    wr_en = 1'b1;
                else if (free_found_reg)
                begin
                    wr_en     = 1'b1;
                    wr_idx    = free_idx_reg;
                    used_next = used_reg + 1'b1;
                end
                else
                    status_next = rapwm_pkg::ST_FULL;
                if (wr_en)
                begin
                    valid_next[wr_idx] = 1'b1;
                    idx_next   = wr_idx;
                    eaddr_next = addr_reg;
                    ech_next   = ch_reg;
                end
            end
            rapwm_pkg::OP_REMOVE:
            begin
                if (found_reg)
                begin
                    valid_next[match_idx_reg] = 1'b0;
                    used_next  = used_reg - 1'b1;
                    idx_next   = match_idx_reg;
                    eaddr_next = match_addr_reg;
                    ech_next   = match_ch_reg;
                end
                else
                    status_next = rapwm_pkg::ST_NOT_FOUND;
            end
            rapwm_pkg::OP_CLEAR:
            begin
                valid_next = '0;
                used_next  = '0;
            end
            rapwm_pkg::OP_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            default:
            begin
                status_next = rapwm_pkg::ST_OK;
            end
        endcase
    end

    assign wr_data = '{name: key_reg, len: len_reg, addr: addr_reg, ch: ch_reg};

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.finish && wr_en)
            mem[wr_idx] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
        rd_idx_reg <= cmd.rd_addr;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            used_reg       <= '0;
            alert_reg      <= '0;
            sweep_reg      <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (hit && !found_reg)
                    found_reg <= 1'b1;
                if (rd_valid_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
                    free_found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                valid_reg <= valid_next;
                used_reg  <= used_next;
                alert_reg <= alert_next;
                sweep_reg <= sweep_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            len_reg  <= name_length;
            key_reg  <= key_next;
            addr_reg <= station_address;
            ch_reg   <= radio_channel;
        end
        if (!cmd.load && hit && !found_reg)
        begin
            match_idx_reg  <= rd_idx_reg;
            match_addr_reg <= rd_data_reg.addr;
            match_ch_reg   <= rd_data_reg.ch;
        end
        if (!cmd.load && rd_valid_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
            free_idx_reg <= rd_idx_reg;
        if (cmd.finish)
        begin
            status_reg <= status_next;
            ev_reg     <= ev_next;
            idx_reg    <= idx_next;
            eaddr_reg  <= eaddr_next;
            ech_reg    <= ech_next;
        end
    end

    assign status           = status_reg;
    assign event_kind       = ev_reg;
    assign entry_index      = rapwm_pkg::OUT_IDX_W'(idx_reg);
    assign expected_address = eaddr_reg;
    assign expected_channel = ech_reg;
    assign alert_total      = alert_reg;
    assign sweep_total      = sweep_reg;
    assign entries_in_use   = used_reg;

endmodule

// ----- design/rogue_ap_whitelist_matcher_core.sv -----
// ----------------------------------------------------------------------------
// rogue_ap_whitelist_matcher_core
// trusted access point table with add, remove, clear, sweep and check
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid / in_stall carries one command beat: opcode, name
//   (length and four 8-byte words), station address and radio channel
// - output channel out_valid / out_stall returns one result beat per command:
//   status, event kind, entry index, stored address and channel, the alert
//   and sweep totals and the number of entries in use
// - a beat is taken when valid is high and stall is low at a rising edge
// - after the input beat the controller reads every one of the 16 table
//   entries through the single memory read port, one per cycle, then does
//   the last compare and then the commit, after which out_valid rises
// - a new command is taken only after the commit of the previous one, once
//   the controller is back in idle
// - the next command is taken while the previous result still waits in the
//   output register; the commit of that command then holds until the output
//   register is free, and in_stall stays high meanwhile
// - reset (rst_n low, asynchronous) empties the table and zeroes both totals;
//   entry contents are not cleared since only valid entries are ever compared
// ----------------------------------------------------------------------------
module rogue_ap_whitelist_matcher_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rapwm_pkg::OP_W-1:0]        opcode,
    input  logic [rapwm_pkg::LEN_W-1:0]       name_length,
    input  logic [63:0]                       name_bytes_0_7,
    input  logic [63:0]                       name_bytes_8_15,
    input  logic [63:0]                       name_bytes_16_23,
    input  logic [63:0]                       name_bytes_24_31,
    input  logic [rapwm_pkg::ADDR_W-1:0]      station_address,
    input  logic [rapwm_pkg::CH_W-1:0]        radio_channel,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rapwm_pkg::ST_W-1:0]        status,
    output logic [rapwm_pkg::EV_W-1:0]        event_kind,
    output logic [rapwm_pkg::OUT_IDX_W-1:0]   entry_index,
    output logic [rapwm_pkg::ADDR_W-1:0]      expected_address,
    output logic [rapwm_pkg::CH_W-1:0]        expected_channel,
    output logic [rapwm_pkg::TOT_W-1:0]       alert_total,
    output logic [rapwm_pkg::TOT_W-1:0]       sweep_total,
    output logic [rapwm_pkg::CNT_W-1:0]       entries_in_use
);

    // commands from the sequencer to the datapath
    rapwm_pkg::cmd_t cmd;

    // sequencer: idle, table scan, last compare, commit
    rapwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: key build, table memory, compare, counters, result register
    rapwm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .opcode           (opcode),
        .name_length      (name_length),
        .name_bytes_0_7   (name_bytes_0_7),
        .name_bytes_8_15  (name_bytes_8_15),
        .name_bytes_16_23 (name_bytes_16_23),
        .name_bytes_24_31 (name_bytes_24_31),
        .station_address  (station_address),
        .radio_channel    (radio_channel),
        .status           (status),
        .event_kind       (event_kind),
        .entry_index      (entry_index),
        .expected_address (expected_address),
        .expected_channel (expected_channel),
        .alert_total      (alert_total),
        .sweep_total      (sweep_total),
        .entries_in_use   (entries_in_use)
    );

endmodule

// ----- tb/rogue_ap_whitelist_matcher_core_tb.sv -----
// ----------------------------------------------------------------------------
// rogue_ap_whitelist_matcher_core_tb
// self-checking bench for the trusted access point table
//
// a queue of command beats is built up front: a short directed list first
// (length and channel limits, name sanitizing, overwrite, raw-name remove,
// rogue and mismatch events, unknown opcodes, clear), then random traffic
// drawn mostly from a small pool of names so the table fills, overflows and
// matches often. a clocked driver plays the queue out and predicts each
// result when its beat is taken; a clocked monitor checks every result beat
// field by field against the oldest prediction. both sides idle at random
// in the first two of three phases; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module rogue_ap_whitelist_matcher_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no beat on either channel before the run is called hung
    localparam int HANG_LIMIT  = 2000;
    // quiet cycles after the last result, to catch stray result beats
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_ITEMS  = 1550;
    localparam int POOL_NAMES  = 24;
    // pool names at or above this index may carry bytes that get sanitized
    localparam int DIRTY_FIRST = 20;

    // one command beat, name byte 0 in the lowest bits
    typedef struct packed {
        logic [rapwm_pkg::OP_W-1:0]   op;
        logic [rapwm_pkg::LEN_W-1:0]  len;
        logic [rapwm_pkg::NAME_W-1:0] name;
        logic [rapwm_pkg::ADDR_W-1:0] addr;
        logic [rapwm_pkg::CH_W-1:0]   ch;
    } cmd_beat_t;

    // one result beat
    typedef struct packed {
        logic [rapwm_pkg::ST_W-1:0]      st;
        logic [rapwm_pkg::EV_W-1:0]      ev;
        logic [rapwm_pkg::OUT_IDX_W-1:0] idx;
        logic [rapwm_pkg::ADDR_W-1:0]    addr;
        logic [rapwm_pkg::CH_W-1:0]      ch;
        logic [rapwm_pkg::TOT_W-1:0]     alerts;
        logic [rapwm_pkg::TOT_W-1:0]     sweeps;
        logic [rapwm_pkg::CNT_W-1:0]     used;
    } result_beat_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [rapwm_pkg::OP_W-1:0]      opcode = '0;
    logic [rapwm_pkg::LEN_W-1:0]     name_length = '0;
    logic [63:0]                     name_bytes_0_7 = '0;
    logic [63:0]                     name_bytes_8_15 = '0;
    logic [63:0]                     name_bytes_16_23 = '0;
    logic [63:0]                     name_bytes_24_31 = '0;
    logic [rapwm_pkg::ADDR_W-1:0]    station_address = '0;
    logic [rapwm_pkg::CH_W-1:0]      radio_channel = '0;

    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [rapwm_pkg::ST_W-1:0]      status;
    logic [rapwm_pkg::EV_W-1:0]      event_kind;
    logic [rapwm_pkg::OUT_IDX_W-1:0] entry_index;
    logic [rapwm_pkg::ADDR_W-1:0]    expected_address;
    logic [rapwm_pkg::CH_W-1:0]      expected_channel;
    logic [rapwm_pkg::TOT_W-1:0]     alert_total;
    logic [rapwm_pkg::TOT_W-1:0]     sweep_total;
    logic [rapwm_pkg::CNT_W-1:0]     entries_in_use;

    // command beats still to send, and results predicted but not yet seen
    cmd_beat_t    pending_cmds[$];
    result_beat_t predicted_results[$];

    cmd_beat_t    cur_beat;
    cmd_beat_t    next_beat;
    result_beat_t want;

    // shadow copy of the whitelist and the two totals
    logic                         wl_valid [rapwm_pkg::ENTRIES];
    logic [rapwm_pkg::NAME_W-1:0] wl_name  [rapwm_pkg::ENTRIES];
    logic [rapwm_pkg::LEN_W-1:0]  wl_len   [rapwm_pkg::ENTRIES];
    logic [rapwm_pkg::ADDR_W-1:0] wl_addr  [rapwm_pkg::ENTRIES];
    logic [rapwm_pkg::CH_W-1:0]   wl_ch    [rapwm_pkg::ENTRIES];
    logic [rapwm_pkg::TOT_W-1:0]  alert_cnt;
    logic [rapwm_pkg::TOT_W-1:0]  sweep_cnt;

    int n_loaded = 0;
    int total_items = 1;
    int n_errors = 0;
    int quiet_cycles = 0;
    int gap_pct;
    int stall_pct;

    rogue_ap_whitelist_matcher_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .name_length      (name_length),
        .name_bytes_0_7   (name_bytes_0_7),
        .name_bytes_8_15  (name_bytes_8_15),
        .name_bytes_16_23 (name_bytes_16_23),
        .name_bytes_24_31 (name_bytes_24_31),
        .station_address  (station_address),
        .radio_channel    (radio_channel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .event_kind       (event_kind),
        .entry_index      (entry_index),
        .expected_address (expected_address),
        .expected_channel (expected_channel),
        .alert_total      (alert_total),
        .sweep_total      (sweep_total),
        .entries_in_use   (entries_in_use)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    function automatic logic [rapwm_pkg::NAME_W-1:0] rand_name_bits();
        logic [rapwm_pkg::NAME_W-1:0] v;
        for (int k = 0; k < rapwm_pkg::NAME_W / 32; k++)
            v[32*k +: 32] = $urandom;
        return v;
    endfunction

    function automatic logic [rapwm_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[rapwm_pkg::ADDR_W-1:0];
    endfunction

    // ascii text to name bytes, first character in the lowest byte
    function automatic logic [rapwm_pkg::NAME_W-1:0] str_name(string s);
        logic [rapwm_pkg::NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < rapwm_pkg::NAME_BYTES; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // queue one command; bytes at and past the length get random junk,
    // which the block must ignore
    task automatic push_cmd(input logic [rapwm_pkg::OP_W-1:0] op,
                            input logic [rapwm_pkg::LEN_W-1:0] len,
                            input logic [rapwm_pkg::NAME_W-1:0] nm,
                            input logic [rapwm_pkg::ADDR_W-1:0] a,
                            input logic [rapwm_pkg::CH_W-1:0] ch);
        cmd_beat_t                    b;
        logic [rapwm_pkg::NAME_W-1:0] junk;
        junk = rand_name_bits();
        for (int i = 0; i < rapwm_pkg::NAME_BYTES; i++)
            if (i >= len)
                nm[8*i +: 8] = junk[8*i +: 8];
        b.op   = op;
        b.len  = len;
        b.name = nm;
        b.addr = a;
        b.ch   = ch;
        pending_cmds.push_back(b);
    endtask

    // first valid entry holding exactly this (already masked) name
    function automatic int find_entry(logic [rapwm_pkg::NAME_W-1:0] nm,
                                      logic [rapwm_pkg::LEN_W-1:0] len);
        for (int e = 0; e < rapwm_pkg::ENTRIES; e++)
            if (wl_valid[e] && wl_len[e] == len && wl_name[e] == nm)
                return e;
        return -1;
    endfunction

    // ------------------------------------------------------------------------
    // result predictor: applies one command to the shadow table
    // ------------------------------------------------------------------------
    function automatic result_beat_t predict_result(cmd_beat_t c);
        logic [rapwm_pkg::NAME_W-1:0] nm;
        logic [7:0]                   b;
        int                           lim;
        int                           hit;
        int                           used;
        result_beat_t                 r;

        // only the first length bytes count, never more than the name size
        lim = (c.len > rapwm_pkg::NAME_BYTES) ? rapwm_pkg::NAME_BYTES : int'(c.len);
        nm  = '0;
        for (int i = 0; i < rapwm_pkg::NAME_BYTES; i++)
            if (i < lim)
                nm[8*i +: 8] = c.name[8*i +: 8];

        r    = '0;
        r.st = rapwm_pkg::ST_OK;
        r.ev = rapwm_pkg::EV_NONE;
        hit  = -1;

        case (c.op)
            rapwm_pkg::OP_CHECK:
            begin
                // raw bytes against stored names; address wins over channel
                hit = find_entry(nm, c.len);
                if (hit >= 0)
                begin
                    if (wl_addr[hit] != c.addr)
                        r.ev = rapwm_pkg::EV_ROGUE;
                    else if (wl_ch[hit] != '0 && wl_ch[hit] != c.ch)
                        r.ev = rapwm_pkg::EV_MISMATCH;
                    if (r.ev != rapwm_pkg::EV_NONE)
                        alert_cnt = alert_cnt + 1'b1;
                end
            end
            rapwm_pkg::OP_ADD:
            begin
                if (c.len == '0 || c.len > rapwm_pkg::NAME_BYTES)
                    r.st = rapwm_pkg::ST_BAD_LEN;
                else if (c.ch > rapwm_pkg::CH_MAX)
                    r.st = rapwm_pkg::ST_BAD_CH;
                else
                begin
                    // comma, bar and control bytes are stored as underscore
                    for (int i = 0; i < rapwm_pkg::NAME_BYTES; i++)
                    begin
                        b = nm[8*i +: 8];
                        if (i < lim && (b == rapwm_pkg::CHAR_COMMA ||
                                        b == rapwm_pkg::CHAR_BAR ||
                                        b < rapwm_pkg::CHAR_SPACE))
                            nm[8*i +: 8] = rapwm_pkg::CHAR_UNDERSCORE;
                    end
                    hit = find_entry(nm, c.len);
                    if (hit < 0)
                    begin
                        for (int e = rapwm_pkg::ENTRIES - 1; e >= 0; e--)
                            if (!wl_valid[e])
                                hit = e;
                    end
                    if (hit < 0)
                        r.st = rapwm_pkg::ST_FULL;
                    else
                    begin
                        wl_valid[hit] = 1'b1;
                        wl_name[hit]  = nm;
                        wl_len[hit]   = c.len;
                        wl_addr[hit]  = c.addr;
                        wl_ch[hit]    = c.ch;
                    end
                end
            end
            rapwm_pkg::OP_REMOVE:
            begin
                hit = find_entry(nm, c.len);
                if (hit < 0)
                    r.st = rapwm_pkg::ST_NOT_FOUND;
                else
                    wl_valid[hit] = 1'b0;
            end
            rapwm_pkg::OP_CLEAR:
            begin
                for (int e = 0; e < rapwm_pkg::ENTRIES; e++)
                    wl_valid[e] = 1'b0;
            end
            rapwm_pkg::OP_SWEEP:
            begin
                sweep_cnt = sweep_cnt + 1'b1;
            end
            default:
            begin
                // unknown opcodes leave everything alone
            end
        endcase

        used = 0;
        for (int e = 0; e < rapwm_pkg::ENTRIES; e++)
            if (wl_valid[e])
                used++;

        // a removed entry still reports what it held
        if (hit >= 0)
        begin
            r.idx  = rapwm_pkg::OUT_IDX_W'(hit);
            r.addr = wl_addr[hit];
            r.ch   = wl_ch[hit];
        end
        r.alerts = alert_cnt;
        r.sweeps = sweep_cnt;
        r.used   = rapwm_pkg::CNT_W'(used);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // idling phases: sender light and receiver heavy, then swapped, then none
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (n_loaded < total_items / 3)
        begin
            gap_pct   = 31;
            stall_pct = 75;
        end
        else if (n_loaded < (2 * total_items) / 3)
        begin
            gap_pct   = 75;
            stall_pct = 31;
        end
        else
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
    end

    // ------------------------------------------------------------------------
    // driver: predicts each command beat as it is taken, then loads the next
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid         <= 1'b0;
            opcode           <= '0;
            name_length      <= '0;
            name_bytes_0_7   <= '0;
            name_bytes_8_15  <= '0;
            name_bytes_16_23 <= '0;
            name_bytes_24_31 <= '0;
            station_address  <= '0;
            radio_channel    <= '0;
            for (int e = 0; e < rapwm_pkg::ENTRIES; e++)
            begin
                wl_valid[e] = 1'b0;
                wl_name[e]  = '0;
                wl_len[e]   = '0;
                wl_addr[e]  = '0;
                wl_ch[e]    = '0;
            end
            alert_cnt = '0;
            sweep_cnt = '0;
        end
        else
        begin
            // beat taken at this edge
            if (in_valid && !in_stall)
                predicted_results.push_back(predict_result(cur_beat));

            // the payload holds while stalled; otherwise send or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    next_beat = pending_cmds.pop_front();
                    cur_beat         <= next_beat;
                    opcode           <= next_beat.op;
                    name_length      <= next_beat.len;
                    name_bytes_0_7   <= next_beat.name[63:0];
                    name_bytes_8_15  <= next_beat.name[127:64];
                    name_bytes_16_23 <= next_beat.name[191:128];
                    name_bytes_24_31 <= next_beat.name[255:192];
                    station_address  <= next_beat.addr;
                    radio_channel    <= next_beat.ch;
                    in_valid         <= 1'b1;
                    n_loaded         <= n_loaded + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    n_errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        n_errors++;
                    end
                    if (event_kind !== want.ev)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.ev, event_kind);
                        n_errors++;
                    end
                    if (entry_index !== want.idx)
                    begin
                        $error("entry_index: expected %0d, got %0d", want.idx, entry_index);
                        n_errors++;
                    end
                    if (expected_address !== want.addr)
                    begin
                        $error("expected_address: expected %h, got %h",
                               want.addr, expected_address);
                        n_errors++;
                    end
                    if (expected_channel !== want.ch)
                    begin
                        $error("expected_channel: expected %0d, got %0d",
                               want.ch, expected_channel);
                        n_errors++;
                    end
                    if (alert_total !== want.alerts)
                    begin
                        $error("alert_total: expected %0d, got %0d", want.alerts, alert_total);
                        n_errors++;
                    end
                    if (sweep_total !== want.sweeps)
                    begin
                        $error("sweep_total: expected %0d, got %0d", want.sweeps, sweep_total);
                        n_errors++;
                    end
                    if (entries_in_use !== want.used)
                    begin
                        $error("entries_in_use: expected %0d, got %0d",
                               want.used, entries_in_use);
                        n_errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("rogue_ap_whitelist_matcher_core_tb: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [rapwm_pkg::NAME_W-1:0] office;
        logic [rapwm_pkg::NAME_W-1:0] all_ff;
        logic [rapwm_pkg::NAME_W-1:0] dirty;
        logic [rapwm_pkg::NAME_W-1:0] clean;
        logic [rapwm_pkg::NAME_W-1:0] pool_name [POOL_NAMES];
        logic [rapwm_pkg::LEN_W-1:0]  pool_len  [POOL_NAMES];
        logic [rapwm_pkg::ADDR_W-1:0] pool_addr [POOL_NAMES];
        logic [rapwm_pkg::CH_W-1:0]   pool_ch   [POOL_NAMES];
        logic [7:0]                   b;
        logic [rapwm_pkg::ADDR_W-1:0] a;
        logic [rapwm_pkg::CH_W-1:0]   ch;
        int                           r;
        int                           p;

        office = str_name("office");
        all_ff = '1;
        // comma, bar, zero and a control byte get sanitized; space and 0x7f stay
        dirty = str_name("a,b|c");
        dirty[8*5 +: 8] = 8'h00;
        dirty[8*6 +: 8] = 8'h1f;
        dirty[8*7 +: 8] = rapwm_pkg::CHAR_SPACE;
        dirty[8*8 +: 8] = 8'h7f;
        clean = str_name("a_b_c__");
        clean[8*7 +: 8] = rapwm_pkg::CHAR_SPACE;
        clean[8*8 +: 8] = 8'h7f;

        // directed part
        push_cmd(rapwm_pkg::OP_SWEEP, '0, '0, '0, '0);
        push_cmd(rapwm_pkg::OP_CHECK, 6, office, 48'h1, 8'd1);            // empty table
        push_cmd(rapwm_pkg::OP_ADD, 0, office, 48'h1, 8'd1);              // zero length
        push_cmd(rapwm_pkg::OP_ADD, 33, office, 48'h1, 8'd1);             // one past limit
        push_cmd(rapwm_pkg::OP_ADD, '1, all_ff, 48'h1, 8'd1);             // longest code
        push_cmd(rapwm_pkg::OP_ADD, 6, office, 48'h1, rapwm_pkg::CH_MAX + 8'd1);
        push_cmd(rapwm_pkg::OP_ADD, 6, office, 48'h1, '1);
        push_cmd(rapwm_pkg::OP_ADD, 0, office, 48'h1, '1);                // length first
        push_cmd(rapwm_pkg::OP_ADD, 6, office, '0, '0);                   // any channel
        push_cmd(rapwm_pkg::OP_ADD, 32, all_ff, '1, rapwm_pkg::CH_MAX);   // full-size name
        push_cmd(rapwm_pkg::OP_ADD, 9, dirty, 48'h0a1b2c3d4e5f, 8'd1);    // sanitized
        push_cmd(rapwm_pkg::OP_CHECK, 6, office, '0, 8'd9);               // any channel
        push_cmd(rapwm_pkg::OP_CHECK, 32, all_ff, '1, rapwm_pkg::CH_MAX); // exact hit
        push_cmd(rapwm_pkg::OP_CHECK, 32, all_ff, '1, 8'd3);              // ch mismatch
        push_cmd(rapwm_pkg::OP_CHECK, 32, all_ff, 48'h1, rapwm_pkg::CH_MAX); // rogue
        push_cmd(rapwm_pkg::OP_CHECK, 9, dirty, 48'h0a1b2c3d4e5f, 8'd1);  // raw misses
        push_cmd(rapwm_pkg::OP_CHECK, 9, clean, 48'h0a1b2c3d4e5f, 8'd2);  // sanitized hits
        push_cmd(rapwm_pkg::OP_CHECK, 33, office, '0, '0);                // long name
        push_cmd(rapwm_pkg::OP_ADD, 6, office, 48'h123456789abc, 8'd7);   // overwrite
        push_cmd(rapwm_pkg::OP_REMOVE, 9, dirty, '0, '0);                 // raw not found
        push_cmd(rapwm_pkg::OP_REMOVE, 9, clean, '0, '0);
        push_cmd(rapwm_pkg::OP_REMOVE, 7, str_name("nothere"), '0, '0);
        for (int k = rapwm_pkg::OP_SWEEP + 1; k < (1 << rapwm_pkg::OP_W); k++)
            push_cmd(rapwm_pkg::OP_W'(k), rapwm_pkg::LEN_W'($urandom), rand_name_bits(),
                     rand_addr(), rapwm_pkg::CH_W'($urandom));
        push_cmd(rapwm_pkg::OP_CLEAR, '0, '0, '0, '0);
        push_cmd(rapwm_pkg::OP_CHECK, 6, office, 48'h123456789abc, 8'd7); // gone

        // name pool: mostly clean short names, a few long, the last ones dirty
        for (int q = 0; q < POOL_NAMES; q++)
        begin
            if (q == 0)
                pool_len[q] = rapwm_pkg::LEN_W'(rapwm_pkg::NAME_BYTES);
            else if ($urandom_range(3) == 0)
                pool_len[q] = rapwm_pkg::LEN_W'($urandom_range(9, rapwm_pkg::NAME_BYTES));
            else
                pool_len[q] = rapwm_pkg::LEN_W'($urandom_range(1, 8));
            pool_name[q] = '0;
            for (int i = 0; i < rapwm_pkg::NAME_BYTES; i++)
            begin
                b = 8'($urandom_range(33, 126));
                if (b == rapwm_pkg::CHAR_COMMA || b == rapwm_pkg::CHAR_BAR)
                    b = rapwm_pkg::CHAR_UNDERSCORE;
                if (q >= DIRTY_FIRST && $urandom_range(2) == 0)
                    b = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 31))
                                                 : rapwm_pkg::CHAR_COMMA;
                if (i < pool_len[q])
                    pool_name[q][8*i +: 8] = b;
            end
            pool_addr[q] = rand_addr();
            pool_ch[q]   = ($urandom_range(3) == 0) ? '0 :
                           rapwm_pkg::CH_W'($urandom_range(1, rapwm_pkg::CH_MAX));
        end

        // random part: well-formed commands on pool names, plus some noise
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            r = $urandom_range(99);
            p = $urandom_range(POOL_NAMES - 1);
            if (r < 40)
            begin
                a  = ($urandom_range(9) < 8) ? pool_addr[p] : rand_addr();
                ch = ($urandom_range(3) != 0) ? pool_ch[p] :
                     rapwm_pkg::CH_W'($urandom_range(255));
                push_cmd(rapwm_pkg::OP_CHECK, pool_len[p], pool_name[p], a, ch);
            end
            else if (r < 70)
            begin
                a  = ($urandom_range(9) < 8) ? pool_addr[p] : rand_addr();
                ch = ($urandom_range(3) != 0) ? pool_ch[p] :
                     rapwm_pkg::CH_W'($urandom_range(rapwm_pkg::CH_MAX));
                push_cmd(rapwm_pkg::OP_ADD, pool_len[p], pool_name[p], a, ch);
            end
            else if (r < 80)
                push_cmd(rapwm_pkg::OP_REMOVE, pool_len[p], pool_name[p], rand_addr(),
                         rapwm_pkg::CH_W'($urandom));
            else if (r < 81)
                push_cmd(rapwm_pkg::OP_CLEAR, rapwm_pkg::LEN_W'($urandom), rand_name_bits(),
                         rand_addr(), rapwm_pkg::CH_W'($urandom));
            else if (r < 89)
                push_cmd(rapwm_pkg::OP_SWEEP, rapwm_pkg::LEN_W'($urandom), rand_name_bits(),
                         rand_addr(), rapwm_pkg::CH_W'($urandom));
            else
                push_cmd(rapwm_pkg::OP_W'($urandom), rapwm_pkg::LEN_W'($urandom),
                         rand_name_bits(), rand_addr(), rapwm_pkg::CH_W'($urandom));
        end

        total_items = pending_cmds.size();

        // single reset at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // look at the queues away from the active edge
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || predicted_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (n_errors == 0)
            $display("rogue_ap_whitelist_matcher_core_tb: done, clean");
        else
            $display("rogue_ap_whitelist_matcher_core_tb: done, errors");
        $finish;
    end

endmodule
